// File: design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the bitmap page allocator: map geometry,
// request kinds, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int NUM_BLOCKS     = 4096;
   localparam int BLK_BITS       = 12;
   localparam int CNT_BITS       = 13;
   localparam int ADDR_BITS      = 48;
   localparam int WORD_BITS      = 64;
   localparam int NUM_WORDS      = NUM_BLOCKS / WORD_BITS;
   localparam int WORD_SEL_BITS  = 6;
   localparam int BIT_SEL_BITS   = 6;
   localparam int CHUNK_BITS     = 8;
   localparam int CHUNK_SEL_BITS = 3;
   localparam int POS_BITS       = 3;
   localparam int SHIFT_BITS     = 5;
   localparam int TYPE_BITS      = 32;
   localparam int KIND_BITS      = 2;
   localparam int CSR_IDX_BITS   = 1;

   localparam logic [KIND_BITS-1:0] KIND_ALLOC  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_FREE   = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_REGION = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_QUERY  = 2'd3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_REGION_BASE = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLOCK_SHIFT = 1'b1;

   localparam logic [ADDR_BITS-1:0]  BASE_RESET  = '0;
   localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 5'd12;
   localparam logic [TYPE_BITS-1:0]  TYPE_USABLE = 32'd1;

   typedef enum logic [3:0] {
      STG_NONE,
      STG_P1,
      STG_P2,
      STG_P3,
      STG_P4,
      STG_DECIDE,
      STG_SCAN,
      STG_AL1,
      STG_AL2,
      STG_AL3,
      STG_FILL,
      STG_QRY
   } stage_type;

   typedef enum logic [1:0] {
      OP_DONE,
      OP_SCAN,
      OP_FILL,
      OP_QUERY
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_P1,
      ST_P2,
      ST_P3,
      ST_P4,
      ST_DECIDE,
      ST_SCAN_RD,
      ST_SCAN,
      ST_AL1,
      ST_AL2,
      ST_AL3,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_QRY_RD,
      ST_QRY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic      load;
      stage_type stage;
      logic      mem_rd;
      logic      mem_wr;
      logic      out_load;
   } cmd_type;

   typedef struct packed {
      op_type next_op;
      logic   scan_found;
      logic   chunk_last;
      logic   word_last;
      logic   addr_over;
      logic   fill_last;
   } sts_type;

endpackage

// File: design/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Request sequencer: steps the datapath through setup, map scan, word fill
// and query, and owns the request and response handshakes.
// ----------------------------------------------------------------------------
module bpa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  bpa_pkg::sts_type sts,
   output bpa_pkg::cmd_type cmd
);

   bpa_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.stage    = bpa_pkg::STG_NONE;
      cmd.mem_rd   = 1'b0;
      cmd.mem_wr   = 1'b0;
      cmd.out_load = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         bpa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = bpa_pkg::ST_P1;
            end
         end
         bpa_pkg::ST_P1: begin
            cmd.stage = bpa_pkg::STG_P1;
            state_in  = bpa_pkg::ST_P2;
         end
         bpa_pkg::ST_P2: begin
            cmd.stage = bpa_pkg::STG_P2;
            state_in  = bpa_pkg::ST_P3;
         end
         bpa_pkg::ST_P3: begin
            cmd.stage = bpa_pkg::STG_P3;
            state_in  = bpa_pkg::ST_P4;
         end
         bpa_pkg::ST_P4: begin
            cmd.stage = bpa_pkg::STG_P4;
            state_in  = bpa_pkg::ST_DECIDE;
         end
         bpa_pkg::ST_DECIDE: begin
            cmd.stage = bpa_pkg::STG_DECIDE;
            unique case (sts.next_op)
               bpa_pkg::OP_SCAN:  state_in = bpa_pkg::ST_SCAN_RD;
               bpa_pkg::OP_FILL:  state_in = bpa_pkg::ST_FILL_RD;
               bpa_pkg::OP_QUERY: state_in = bpa_pkg::ST_QRY_RD;
               default:           state_in = bpa_pkg::ST_DONE;
            endcase
         end
         bpa_pkg::ST_SCAN_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = bpa_pkg::ST_SCAN;
         end
         bpa_pkg::ST_SCAN: begin
            cmd.stage = bpa_pkg::STG_SCAN;
            priority if (sts.scan_found)
               state_in = bpa_pkg::ST_AL1;
            else if (sts.chunk_last && sts.word_last)
               state_in = bpa_pkg::ST_DONE;
            else if (sts.chunk_last)
               state_in = bpa_pkg::ST_SCAN_RD;
            else
               state_in = bpa_pkg::ST_SCAN;
         end
         bpa_pkg::ST_AL1: begin
            cmd.stage = bpa_pkg::STG_AL1;
            state_in  = bpa_pkg::ST_AL2;
         end
         bpa_pkg::ST_AL2: begin
            cmd.stage = bpa_pkg::STG_AL2;
            state_in  = bpa_pkg::ST_AL3;
         end
         bpa_pkg::ST_AL3: begin
            cmd.stage = bpa_pkg::STG_AL3;
            state_in  = sts.addr_over ? bpa_pkg::ST_DONE : bpa_pkg::ST_FILL_RD;
         end
         bpa_pkg::ST_FILL_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = bpa_pkg::ST_FILL_WR;
         end
         bpa_pkg::ST_FILL_WR: begin
            cmd.stage  = bpa_pkg::STG_FILL;
            cmd.mem_wr = 1'b1;
            state_in   = sts.fill_last ? bpa_pkg::ST_DONE : bpa_pkg::ST_FILL_RD;
         end
         bpa_pkg::ST_QRY_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = bpa_pkg::ST_QRY;
         end
         bpa_pkg::ST_QRY: begin
            cmd.stage = bpa_pkg::STG_QRY;
            state_in  = bpa_pkg::ST_DONE;
         end
         bpa_pkg::ST_DONE: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = bpa_pkg::ST_IDLE;
            end
         end
         default: state_in = bpa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == bpa_pkg::ST_FILL_WR |-> $past(state_ff) == bpa_pkg::ST_FILL_RD)
      else $error("map word written without a fresh read");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == bpa_pkg::ST_P1)
      else $error("accepted request did not start setup");

endmodule

// File: design/bpa_dpath.sv
// ----------------------------------------------------------------------------
// bpa_dpath
// Datapath: request and register capture, address arithmetic, the free map
// memory with its row valid bits, the run scanner and the word fill unit.
// ----------------------------------------------------------------------------
module bpa_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic [bpa_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [bpa_pkg::ADDR_BITS-1:0]          csr_data,
   input  logic [bpa_pkg::KIND_BITS-1:0]          req_kind,
   input  logic [bpa_pkg::ADDR_BITS-1:0]          req_address,
   input  logic [bpa_pkg::CNT_BITS-1:0]           req_count,
   input  logic [bpa_pkg::ADDR_BITS-1:0]          req_region_length,
   input  logic [bpa_pkg::TYPE_BITS-1:0]          req_region_type,
   input  logic [bpa_pkg::BLK_BITS-1:0]           req_block_index,
   input  bpa_pkg::cmd_type                       cmd,
   output bpa_pkg::sts_type                       sts,
   output logic [bpa_pkg::ADDR_BITS-1:0]          rsp_result_address,
   output logic                                   rsp_status,
   output logic                                   rsp_block_free
);

   localparam int AW = bpa_pkg::ADDR_BITS;
   localparam int WW = AW + 1;
   localparam int CW = bpa_pkg::CNT_BITS;
   localparam int BW = bpa_pkg::BLK_BITS;

   // configuration
   logic [AW-1:0]                    base_ff;
   logic [bpa_pkg::SHIFT_BITS-1:0]   shift_ff;

   // captured request
   logic [bpa_pkg::KIND_BITS-1:0]    kind_ff;
   logic [AW-1:0]                    addr_ff;
   logic [CW-1:0]                    cnt_ff;
   logic [AW-1:0]                    len_ff;
   logic [bpa_pkg::TYPE_BITS-1:0]    rtype_ff;
   logic [BW-1:0]                    bidx_ff;

   // setup temporaries
   logic          a_lt_ff;
   logic [AW-1:0] dab_ff, dba_ff, blk_ff;
   logic [31:0]   bsm1_ff;
   logic [WW-1:0] num_ff, steps_ff, knum_ff, kmin_ff, n_ff, sum_ff;
   logic          b_big_ff, kge_ff;
   logic [BW-1:0] b_ff, end_ff, start_ff;
   logic [BW+1:0] fend_ff;

   // working registers
   logic [BW-1:0]                        lo_ff;
   logic [CW-1:0]                        hi_ff;
   logic                                 set_ff;
   logic [bpa_pkg::WORD_SEL_BITS-1:0]    word_ff;
   logic [bpa_pkg::CHUNK_SEL_BITS-1:0]   chunk_ff;
   logic [CW-1:0]                        run_ff;
   logic                                 ok_ff;
   logic [AW-1:0]                        res_ff;
   logic                                 bfree_ff;

   // output register
   logic [AW-1:0] out_addr_ff;
   logic          out_status_ff;
   logic          out_free_ff;

   // map memory
   logic [bpa_pkg::WORD_BITS-1:0] map_mem_ff [bpa_pkg::NUM_WORDS];
   logic [bpa_pkg::NUM_WORDS-1:0] row_vld_ff;
   logic [bpa_pkg::WORD_BITS-1:0] rdata_ff;
   logic                          rvld_ff;
   logic [bpa_pkg::WORD_BITS-1:0] word_data, fill_mask, wdata;

   // combinational helpers
   logic [31:0]   bs;
   logic [CW-1:0] avail;
   logic          n_gt;
   logic [CW-1:0] hi_m1;
   logic [bpa_pkg::CHUNK_BITS-1:0] chunk_bits;
   logic [CW-1:0] run_v;
   logic          found;
   logic [bpa_pkg::POS_BITS-1:0] pos;
   logic [BW-1:0] idx;

   bpa_pkg::op_type dec_op;
   logic            dec_ok;
   logic [BW-1:0]   dec_lo;
   logic [CW-1:0]   dec_hi;

   assign bs    = 32'd1 << shift_ff;
   assign avail = CW'(bpa_pkg::NUM_BLOCKS) - {1'b0, b_ff};
   assign n_gt  = n_ff > {{(WW-CW){1'b0}}, avail};
   assign hi_m1 = hi_ff - {{(CW-1){1'b0}}, 1'b1};

   assign word_data = rvld_ff ? rdata_ff : '0;

   // decision after setup
   always_comb begin
      dec_op = bpa_pkg::OP_DONE;
      dec_ok = 1'b1;
      dec_lo = b_ff;
      dec_hi = fend_ff[CW-1:0];
      unique case (kind_ff)
         bpa_pkg::KIND_ALLOC: begin
            if (cnt_ff == '0 || cnt_ff > CW'(bpa_pkg::NUM_BLOCKS))
               dec_ok = 1'b0;
            else
               dec_op = bpa_pkg::OP_SCAN;
         end
         bpa_pkg::KIND_FREE: begin
            priority if (a_lt_ff || b_big_ff ||
                         fend_ff > (BW+2)'(bpa_pkg::NUM_BLOCKS))
               dec_ok = 1'b0;
            else if (cnt_ff != '0)
               dec_op = bpa_pkg::OP_FILL;
            else
               dec_ok = 1'b1;
         end
         bpa_pkg::KIND_REGION: begin
            priority if (rtype_ff != bpa_pkg::TYPE_USABLE || len_ff == '0)
               dec_ok = 1'b1;
            else if (kge_ff || b_big_ff)
               dec_ok = 1'b0;
            else begin
               dec_op = bpa_pkg::OP_FILL;
               if (n_gt) begin
                  dec_hi = CW'(bpa_pkg::NUM_BLOCKS);
                  dec_ok = 1'b0;
               end else begin
                  dec_hi = {1'b0, b_ff} + n_ff[CW-1:0];
                  dec_ok = !a_lt_ff;
               end
            end
         end
         bpa_pkg::KIND_QUERY: begin
            dec_op = bpa_pkg::OP_QUERY;
         end
         default: dec_op = bpa_pkg::OP_DONE;
      endcase
   end

   // run search over one 8-bit chunk
   assign chunk_bits = word_data[{chunk_ff, 3'b000} +: bpa_pkg::CHUNK_BITS];

   always_comb begin
      run_v = run_ff;
      found = 1'b0;
      pos   = '0;
      for (int j = 0; j < bpa_pkg::CHUNK_BITS; j++) begin
         run_v = chunk_bits[j] ? run_v + {{(CW-1){1'b0}}, 1'b1} : '0;
         if (!found && run_v == cnt_ff) begin
            found = 1'b1;
            pos   = j[bpa_pkg::POS_BITS-1:0];
         end
      end
   end

   // blocks of the current word inside [lo, hi)
   always_comb begin
      idx = '0;
      for (int j = 0; j < bpa_pkg::WORD_BITS; j++) begin
         idx          = {word_ff, j[bpa_pkg::BIT_SEL_BITS-1:0]};
         fill_mask[j] = (idx >= lo_ff) && ({1'b0, idx} < hi_ff);
      end
   end

   assign wdata = set_ff ? (word_data | fill_mask) : (word_data & ~fill_mask);

   always_comb begin
      sts.next_op    = dec_op;
      sts.scan_found = found;
      sts.chunk_last = chunk_ff == '1;
      sts.word_last  = word_ff == '1;
      sts.addr_over  = sum_ff[AW];
      sts.fill_last  = word_ff == hi_m1[BW-1:bpa_pkg::BIT_SEL_BITS];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= bpa_pkg::BASE_RESET;
         shift_ff <= bpa_pkg::SHIFT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            bpa_pkg::CSR_REGION_BASE: base_ff  <= csr_data;
            bpa_pkg::CSR_BLOCK_SHIFT: shift_ff <= csr_data[bpa_pkg::SHIFT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // memory and row valid bits
   always_ff @(posedge clock) begin
      if (cmd.mem_wr)
         map_mem_ff[word_ff] <= wdata;
      if (cmd.mem_rd)
         rdata_ff <= map_mem_ff[word_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rvld_ff    <= 1'b0;
      end else begin
         if (cmd.mem_wr)
            row_vld_ff[word_ff] <= 1'b1;
         if (cmd.mem_rd)
            rvld_ff <= row_vld_ff[word_ff];
      end
   end

   // request processing
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         addr_ff  <= req_address;
         cnt_ff   <= req_count;
         len_ff   <= req_region_length;
         rtype_ff <= req_region_type;
         bidx_ff  <= req_block_index;
         ok_ff    <= 1'b1;
         res_ff   <= '0;
         bfree_ff <= 1'b0;
      end
      unique case (cmd.stage)
         bpa_pkg::STG_P1: begin
            a_lt_ff <= addr_ff < base_ff;
            dab_ff  <= addr_ff - base_ff;
            dba_ff  <= base_ff - addr_ff;
            bsm1_ff <= bs - 32'd1;
            num_ff  <= {1'b0, len_ff} + {{(WW-32){1'b0}}, bs - 32'd1};
         end
         bpa_pkg::STG_P2: begin
            blk_ff   <= dab_ff >> shift_ff;
            steps_ff <= num_ff >> shift_ff;
            knum_ff  <= {1'b0, dba_ff} + {{(WW-32){1'b0}}, bsm1_ff};
         end
         bpa_pkg::STG_P3: begin
            kmin_ff  <= a_lt_ff ? (knum_ff >> shift_ff) : '0;
            b_big_ff <= !a_lt_ff && (blk_ff[AW-1:BW] != '0);
            b_ff     <= a_lt_ff ? '0 : blk_ff[BW-1:0];
         end
         bpa_pkg::STG_P4: begin
            n_ff    <= steps_ff - kmin_ff;
            kge_ff  <= kmin_ff >= steps_ff;
            fend_ff <= {2'b00, b_ff} + {1'b0, cnt_ff};
         end
         bpa_pkg::STG_DECIDE: begin
            ok_ff    <= dec_ok;
            lo_ff    <= dec_lo;
            hi_ff    <= dec_hi;
            set_ff   <= 1'b1;
            run_ff   <= '0;
            chunk_ff <= '0;
            if (kind_ff == bpa_pkg::KIND_QUERY)
               word_ff <= bidx_ff[BW-1:bpa_pkg::BIT_SEL_BITS];
            else if (kind_ff == bpa_pkg::KIND_ALLOC)
               word_ff <= '0;
            else
               word_ff <= dec_lo[BW-1:bpa_pkg::BIT_SEL_BITS];
         end
         bpa_pkg::STG_SCAN: begin
            run_ff   <= run_v;
            chunk_ff <= chunk_ff + {{(bpa_pkg::CHUNK_SEL_BITS-1){1'b0}}, 1'b1};
            if (found)
               end_ff <= {word_ff, chunk_ff, pos};
            else if (chunk_ff == '1) begin
               word_ff <= word_ff + {{(bpa_pkg::WORD_SEL_BITS-1){1'b0}}, 1'b1};
               if (word_ff == '1)
                  ok_ff <= 1'b0;
            end
         end
         bpa_pkg::STG_AL1: begin
            start_ff <= BW'(({1'b0, end_ff} + {{(CW-1){1'b0}}, 1'b1}) - cnt_ff);
         end
         bpa_pkg::STG_AL2: begin
            sum_ff <= {1'b0, base_ff} + ({{(WW-BW){1'b0}}, start_ff} << shift_ff);
         end
         bpa_pkg::STG_AL3: begin
            if (sum_ff[AW])
               ok_ff <= 1'b0;
            else begin
               res_ff  <= sum_ff[AW-1:0];
               lo_ff   <= start_ff;
               hi_ff   <= {1'b0, end_ff} + {{(CW-1){1'b0}}, 1'b1};
               set_ff  <= 1'b0;
               word_ff <= start_ff[BW-1:bpa_pkg::BIT_SEL_BITS];
            end
         end
         bpa_pkg::STG_FILL: begin
            word_ff <= word_ff + {{(bpa_pkg::WORD_SEL_BITS-1){1'b0}}, 1'b1};
         end
         bpa_pkg::STG_QRY: begin
            bfree_ff <= word_data[bidx_ff[bpa_pkg::BIT_SEL_BITS-1:0]];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_addr_ff   <= res_ff;
         out_status_ff <= !ok_ff;
         out_free_ff   <= bfree_ff;
      end
   end

   assign rsp_result_address = out_addr_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_block_free     = out_free_ff;

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      cmd.stage == bpa_pkg::STG_FILL |-> ({1'b0, lo_ff} < hi_ff))
      else $error("fill over an empty block range");

endmodule

// File: design/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit physical page allocator over a 4096-block free map.
// ----------------------------------------------------------------------------
// One request at a time, one response per request. Every request goes through
// setup steps P1 to P4 and DECIDE, then the response stage. Allocate then scans
// the map 8 blocks a cycle, with a map read before each 64-block word, from
// block 0 up to the end of the first fitting run, then the address steps AL1 to
// AL3. Free, add region and a successful allocate update the map one 64-block
// word at a time, since each word goes through one read-modify-write on the
// single map memory port. A query reads the word that holds the block.
// The map reads as all used from reset on without any clearing pass.
// The result register lets a new request be taken while a response waits.
module bitmap_page_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bpa_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [bpa_pkg::ADDR_BITS-1:0]       csr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bpa_pkg::KIND_BITS-1:0]       req_kind,
   input  logic [bpa_pkg::ADDR_BITS-1:0]       req_address,
   input  logic [bpa_pkg::CNT_BITS-1:0]        req_count,
   input  logic [bpa_pkg::ADDR_BITS-1:0]       req_region_length,
   input  logic [bpa_pkg::TYPE_BITS-1:0]       req_region_type,
   input  logic [bpa_pkg::BLK_BITS-1:0]        req_block_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bpa_pkg::ADDR_BITS-1:0]       rsp_result_address,
   output logic                                rsp_status,
   output logic                                rsp_block_free
);

   bpa_pkg::cmd_type cmd;
   bpa_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bpa_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_kind           (req_kind),
      .req_address        (req_address),
      .req_count          (req_count),
      .req_region_length  (req_region_length),
      .req_region_type    (req_region_type),
      .req_block_index    (req_block_index),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status),
      .rsp_block_free     (rsp_block_free)
   );

endmodule

// File: tb/sv/tb_bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator
// Self-checking bench for the first-fit page allocator: requests are driven
// from a queue, every response is compared with a bit-level prediction of the
// free map, and register settings change between phases while the block idles.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator;

   localparam int AW = bpa_pkg::ADDR_BITS;
   localparam int NB = bpa_pkg::NUM_BLOCKS;

   typedef struct packed {
      logic [bpa_pkg::KIND_BITS-1:0] kind;
      logic [AW-1:0]                 address;
      logic [bpa_pkg::CNT_BITS-1:0]  count;
      logic [AW-1:0]                 region_length;
      logic [bpa_pkg::TYPE_BITS-1:0] region_type;
      logic [bpa_pkg::BLK_BITS-1:0]  block_index;
   } request_type;

   typedef struct packed {
      logic [AW-1:0] result_address;
      logic          status;
      logic          block_free;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [bpa_pkg::CSR_IDX_BITS-1:0] csr_index = '0;
   logic [AW-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [bpa_pkg::KIND_BITS-1:0] req_kind = '0;
   logic [AW-1:0] req_address = '0;
   logic [bpa_pkg::CNT_BITS-1:0] req_count = '0;
   logic [AW-1:0] req_region_length = '0;
   logic [bpa_pkg::TYPE_BITS-1:0] req_region_type = '0;
   logic [bpa_pkg::BLK_BITS-1:0] req_block_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [AW-1:0] rsp_result_address;
   logic rsp_status;
   logic rsp_block_free;

   bitmap_page_allocator i_dut (.*);

   always #10 clock = ~clock;

   // prediction state
   logic [NB-1:0] free_bits;
   logic [AW-1:0] base_reg;
   logic [bpa_pkg::SHIFT_BITS-1:0] shift_reg;

   request_type pending_reqs[$];
   response_type expected_rsps[$];
   int send_idle_pct = 10;
   int recv_idle_pct = 65;
   logic in_taken = 1'b0;
   logic stall_armed = 1'b0;
   logic stall_used = 1'b0;
   int stall_cnt = 0;
   int errors = 0;
   int accepted = 0;
   int checked = 0;
   int cycles = 0;
   int kind_seen[4] = '{0, 0, 0, 0};

   function automatic response_type predict_request(request_type r);
      response_type o;
      logic [63:0] bs, steps, kmin, d, b, n, a, run, i, start;
      logic [63:0] addr, rlen;
      bit ok;
      o = '0;
      ok = 1'b1;
      addr = {16'd0, r.address};
      rlen = {16'd0, r.region_length};
      case (r.kind)
         bpa_pkg::KIND_ALLOC: begin
            ok = 1'b0;
            run = 0;
            if (r.count != 0 && r.count <= NB) begin
               for (i = 0; i < NB; i++) begin
                  run = free_bits[i] ? run + 1 : 0;
                  if (run == r.count) break;
               end
               if (run == r.count) begin
                  start = i + 1 - r.count;
                  a = base_reg + (start << shift_reg);
                  if (a < (64'd1 << AW)) begin
                     for (i = start; i < start + r.count; i++) free_bits[i] = 1'b0;
                     o.result_address = a[AW-1:0];
                     ok = 1'b1;
                  end
               end
            end
         end
         bpa_pkg::KIND_FREE: begin
            ok = 1'b0;
            if (addr >= base_reg) begin
               b = (addr - base_reg) >> shift_reg;
               if (b < NB && b + r.count <= NB) begin
                  for (i = b; i < b + r.count; i++) free_bits[i] = 1'b1;
                  ok = 1'b1;
               end
            end
         end
         bpa_pkg::KIND_REGION: begin
            if (r.region_type == bpa_pkg::TYPE_USABLE && rlen != 0) begin
               bs = 64'd1 << shift_reg;
               steps = (rlen + bs - 1) >> shift_reg;
               kmin = 0;
               if (addr < base_reg) begin
                  kmin = (base_reg - addr + bs - 1) >> shift_reg;
                  ok = 1'b0;
               end
               if (kmin >= steps) ok = 1'b0;
               else begin
                  d = addr + (kmin << shift_reg) - base_reg;
                  b = d >> shift_reg;
                  n = steps - kmin;
                  if (b >= NB) ok = 1'b0;
                  else begin
                     if (n > NB - b) begin
                        n = NB - b;
                        ok = 1'b0;
                     end
                     for (i = b; i < b + n; i++) free_bits[i] = 1'b1;
                  end
               end
            end
         end
         default: o.block_free = free_bits[r.block_index];
      endcase
      o.status = !ok;
      return o;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || in_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               request_type r;
               r = pending_reqs.pop_front();
               expected_rsps.push_back(predict_request(r));
               kind_seen[r.kind]++;
               req_valid <= 1'b1;
               req_kind <= r.kind;
               req_address <= r.address;
               req_count <= r.count;
               req_region_length <= r.region_length;
               req_region_type <= r.region_type;
               req_block_index <= r.block_index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver, with one long hold-off when armed
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_armed && !stall_used) begin
            stall_used <= 1'b1;
            stall_cnt <= 400;
            rsp_ready <= 1'b0;
         end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= $urandom_range(99) >= recv_idle_pct;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles <= cycles + 1;
      in_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         accepted <= accepted + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         response_type e;
         if (expected_rsps.size() == 0) begin
            $display("%0t: response with none expected, actual %h/%b/%b", $time,
                     rsp_result_address, rsp_status, rsp_block_free);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            checked++;
            if (e.result_address !== rsp_result_address)
               $display("%0t: result_address expected %h actual %h", $time,
                        e.result_address, rsp_result_address);
            if (e.status !== rsp_status)
               $display("%0t: status expected %b actual %b", $time, e.status, rsp_status);
            if (e.block_free !== rsp_block_free)
               $display("%0t: block_free expected %b actual %b", $time,
                        e.block_free, rsp_block_free);
            if (e !== {rsp_result_address, rsp_status, rsp_block_free}) errors++;
         end
      end
      if (cycles > 10000000) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_valid)
         @(posedge clock);
      repeat (700) @(posedge clock);
   endtask

   task automatic write_reg(logic [bpa_pkg::CSR_IDX_BITS-1:0] idx, logic [AW-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == bpa_pkg::CSR_REGION_BASE) base_reg = val;
      else shift_reg = val[bpa_pkg::SHIFT_BITS-1:0];
   endtask

   function automatic request_type make_req(logic [bpa_pkg::KIND_BITS-1:0] k,
                                            logic [63:0] a, int c, logic [63:0] len,
                                            logic [31:0] t, int bi);
      request_type r;
      r.kind = k;
      r.address = a[AW-1:0];
      r.count = c[bpa_pkg::CNT_BITS-1:0];
      r.region_length = len[AW-1:0];
      r.region_type = t;
      r.block_index = bi[bpa_pkg::BLK_BITS-1:0];
      return r;
   endfunction

   function automatic logic [63:0] rand48();
      logic [63:0] v;
      v = {$urandom(), $urandom()};
      return {16'd0, v[AW-1:0]};
   endfunction

   // mostly sensible addresses near the map, some wild ones
   function automatic logic [63:0] map_addr();
      logic [63:0] off;
      if ($urandom_range(9) == 0) return rand48();
      off = ($urandom_range(NB + 64) << shift_reg) + $urandom_range(3);
      if ($urandom_range(7) == 0) return (base_reg - off) & 64'hFFFF_FFFF_FFFF;
      return (base_reg + off) & 64'hFFFF_FFFF_FFFF;
   endfunction

   function automatic int small_count();
      case ($urandom_range(9))
         0: return 0;
         1: return $urandom_range(4096, 8191);
         2: return $urandom_range(64, 4096);
         default: return $urandom_range(1, 20);
      endcase
   endfunction

   task automatic add_random(int n);
      request_type r;
      logic [31:0] t;
      repeat (n) begin
         t = ($urandom_range(3) == 0) ? $urandom() : bpa_pkg::TYPE_USABLE;
         case ($urandom_range(9))
            0, 1, 2, 3: r = make_req(bpa_pkg::KIND_ALLOC, rand48(), small_count(),
                                     rand48(), $urandom(), $urandom());
            4, 5, 6: r = make_req(bpa_pkg::KIND_FREE, map_addr(), small_count(),
                                  rand48(), $urandom(), $urandom());
            7: r = make_req(bpa_pkg::KIND_REGION, map_addr(),
                            0, ($urandom_range(3) == 0) ? rand48()
                               : ($urandom_range(0, 40) << shift_reg) + $urandom_range(1),
                            t, $urandom());
            default: r = make_req(bpa_pkg::KIND_QUERY, rand48(), $urandom(), rand48(),
                                  $urandom(), $urandom());
         endcase
         pending_reqs.push_back(r);
      end
   endtask

   initial begin
      free_bits = '0;
      base_reg = bpa_pkg::BASE_RESET;
      shift_reg = bpa_pkg::SHIFT_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: map all used, then region, edges of each request kind
      pending_reqs.push_back(make_req(bpa_pkg::KIND_QUERY, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_ALLOC, 0, 1, 0, 0, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_REGION, 0, 0, 64'h10000, 32'd2, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_REGION, 0, 0, 0,
                                      bpa_pkg::TYPE_USABLE, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_REGION, 0, 0, 64'h1000_0000,
                                      bpa_pkg::TYPE_USABLE, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_QUERY, 0, 0, 0, 0, 4095));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_ALLOC, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_ALLOC, 0, 4096, 0, 0, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_ALLOC, 0, 8191, 0, 0, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_ALLOC, 0, 1, 0, 0, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_FREE, 64'h0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_FREE, 64'h0, 4096, 0, 0, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_FREE, 64'hFFF000, 2, 0, 0, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_FREE, 64'hFFF123, 1, 0, 0, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_FREE, 64'hFFFF_FFFF_FFFF, 1, 0, 0, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_ALLOC, 0, 37, 0, 0, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_REGION, 64'hFFF800, 0, 64'h3000,
                                      bpa_pkg::TYPE_USABLE, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_REGION, 64'hFFFF_FFFF_FFFF, 0,
                                      64'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_QUERY, 64'hFFFF_FFFF_FFFF, 8191,
                                      64'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 4095));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_QUERY, 0, 0, 0, 0, 40));
      add_random(600);
      drain();

      // high base near the top, tiny blocks; sender mostly idle
      send_idle_pct = 65;
      recv_idle_pct = 10;
      write_reg(bpa_pkg::CSR_REGION_BASE, 48'hFFFF_FFFF_F000);
      write_reg(bpa_pkg::CSR_BLOCK_SHIFT, 48'd0);
      pending_reqs.push_back(make_req(bpa_pkg::KIND_REGION, 64'hFFFF_FFFF_E000, 0,
                                      64'h2000, bpa_pkg::TYPE_USABLE, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_ALLOC, 0, 4096, 0, 0, 0));
      add_random(600);
      drain();

      // huge blocks, region start below base; no idling and a long stall
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(bpa_pkg::CSR_REGION_BASE, 48'h0000_1234_5000);
      write_reg(bpa_pkg::CSR_BLOCK_SHIFT, 48'd30);
      pending_reqs.push_back(make_req(bpa_pkg::KIND_REGION, 0, 0, 64'hFFFF_FFFF_FFFF,
                                      bpa_pkg::TYPE_USABLE, 0));
      pending_reqs.push_back(make_req(bpa_pkg::KIND_ALLOC, 0, 4096, 0, 0, 0));
      add_random(10);
      @(negedge clock);
      stall_armed = 1'b1;
      drain();
      write_reg(bpa_pkg::CSR_BLOCK_SHIFT, 48'd7);
      add_random(800);
      drain();

      $display("covered %0d requests (alloc %0d free %0d region %0d query %0d), %0d checked",
               accepted, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], checked);
      $display("register settings: reset, high base with 1-byte blocks, 1 GiB and 128-byte blocks");
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
